>>> rtl/atn_pkg.sv
package atn_pkg;

    localparam int unsigned CP_W     = 21;
    localparam int unsigned QDEPTH   = 4;
    localparam int unsigned QCNT_W   = 3;

    // Codepoints that are dropped or rewritten, and the fold targets
    localparam logic [CP_W-1:0] CP_MARK_A_LO    = 21'h00064B;
    localparam logic [CP_W-1:0] CP_MARK_A_HI    = 21'h00065F;
    localparam logic [CP_W-1:0] CP_SUPER_ALEF   = 21'h000670;
    localparam logic [CP_W-1:0] CP_MARK_B_LO    = 21'h0006D6;
    localparam logic [CP_W-1:0] CP_MARK_B_HI    = 21'h0006ED;
    localparam logic [CP_W-1:0] CP_TATWEEL      = 21'h000640;
    localparam logic [CP_W-1:0] CP_ALEF_MADDA   = 21'h000622;
    localparam logic [CP_W-1:0] CP_ALEF_HAMZA_A = 21'h000623;
    localparam logic [CP_W-1:0] CP_ALEF_HAMZA_B = 21'h000625;
    localparam logic [CP_W-1:0] CP_ALEF_WASLA   = 21'h000671;
    localparam logic [CP_W-1:0] CP_ALEF         = 21'h000627;
    localparam logic [CP_W-1:0] CP_ALEF_MAQSURA = 21'h000649;
    localparam logic [CP_W-1:0] CP_YEH          = 21'h00064A;
    localparam logic [CP_W-1:0] CP_TEH_MARBUTA  = 21'h000629;
    localparam logic [CP_W-1:0] CP_HEH          = 21'h000647;

    typedef struct packed {
        logic load;     // input transfer this cycle
        logic shift;    // output transfer this cycle
    } atn_cmd_t;

    typedef struct packed {
        logic has_result;   // accepted byte produces at least one output transfer
        logic last;         // byte at head of queue is the last of the run
    } atn_status_t;

    typedef struct packed {
        logic [QDEPTH-1:0][7:0] bytes;  // index 0 goes out first
        logic [QCNT_W-1:0]      nbytes;
    } atn_enc_t;

    // Sequence length from lead byte, 0 for an invalid lead
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b[7] == 1'b0)
            len = 3'd1;
        else if (b[7:5] == 3'b110)
            len = 3'd2;
        else if (b[7:4] == 4'b1110)
            len = 3'd3;
        else if (b[7:3] == 5'b11110)
            len = 3'd4;
        return len;
    endfunction

    function automatic logic [CP_W-1:0] decode_seq(input logic [7:0] p0, input logic [7:0] p1,
                                                   input logic [7:0] p2, input logic [7:0] p3,
                                                   input logic [2:0] len);
        logic [CP_W-1:0] cp;
        case (len)
            3'd1:    cp = {13'd0, p0};
            3'd2:    cp = {10'd0, p0[4:0], p1[5:0]};
            3'd3:    cp = {5'd0, p0[3:0], p1[5:0], p2[5:0]};
            3'd4:    cp = {p0[2:0], p1[5:0], p2[5:0], p3[5:0]};
            default: cp = '0;
        endcase
        return cp;
    endfunction

    // Filter, fold letter variants, re-encode in shortest UTF-8 form
    function automatic atn_enc_t encode_cp(input logic [CP_W-1:0] cp_in);
        atn_enc_t        e;
        logic [CP_W-1:0] cp;
        logic            drop;
        e    = '0;
        cp   = cp_in;
        drop = (cp == '0) || (cp == CP_TATWEEL) || (cp == CP_SUPER_ALEF) ||
               ((cp >= CP_MARK_A_LO) && (cp <= CP_MARK_A_HI)) ||
               ((cp >= CP_MARK_B_LO) && (cp <= CP_MARK_B_HI));
        if ((cp == CP_ALEF_MADDA) || (cp == CP_ALEF_HAMZA_A) ||
            (cp == CP_ALEF_HAMZA_B) || (cp == CP_ALEF_WASLA))
            cp = CP_ALEF;
        if (cp == CP_ALEF_MAQSURA)
            cp = CP_YEH;
        if (cp == CP_TEH_MARBUTA)
            cp = CP_HEH;
        if (!drop) begin
            if (cp < 21'h000080) begin
                e.bytes[0] = cp[7:0];
                e.nbytes   = 3'd1;
            end else if (cp < 21'h000800) begin
                e.bytes[0] = {3'b110, cp[10:6]};
                e.bytes[1] = {2'b10, cp[5:0]};
                e.nbytes   = 3'd2;
            end else if (cp < 21'h010000) begin
                e.bytes[0] = {4'b1110, cp[15:12]};
                e.bytes[1] = {2'b10, cp[11:6]};
                e.bytes[2] = {2'b10, cp[5:0]};
                e.nbytes   = 3'd3;
            end else begin
                e.bytes[0] = {5'b11110, cp[20:18]};
                e.bytes[1] = {2'b10, cp[17:12]};
                e.bytes[2] = {2'b10, cp[11:6]};
                e.bytes[3] = {2'b10, cp[5:0]};
                e.nbytes   = 3'd4;
            end
        end
        return e;
    endfunction

endpackage

>>> rtl/atn_ctrl.sv
module atn_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  atn_pkg::atn_status_t status,
    output atn_pkg::atn_cmd_t    cmd
);
    import atn_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SEND = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_SEND);

    assign cmd.load  = in_valid && (state_reg == ST_IDLE);
    assign cmd.shift = out_valid && !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load && status.has_result)
                    state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (cmd.shift && status.last)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> rtl/atn_datapath.sv
module atn_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  atn_pkg::atn_cmd_t    cmd,
    output atn_pkg::atn_status_t status,
    input  logic [7:0]           in_byte,
    input  logic                 final_byte,
    output logic [7:0]           out_byte,
    output logic                 has_byte,
    output logic                 last_of_run,
    output logic                 end_of_text
);
    import atn_pkg::*;

    // partial sequence
    logic [7:0]              held0_reg, held1_reg, held2_reg;
    logic [7:0]              held0_next, held1_next, held2_next;
    logic [1:0]              cnt_reg, cnt_next, cnt_step;
    logic [2:0]              slen_reg, slen_next, slen_step;
    // output byte queue
    logic [QDEPTH-1:0][7:0]  q_reg, q_load;
    logic [QCNT_W-1:0]       qcnt_reg, qcnt_load;
    logic                    fin_reg;

    logic                    idle_path, complete;
    logic [2:0]              b_len, l1, l2;
    logic [7:0]              s1, s2;
    logic                    main_emit, fa_valid, fb_keep;
    logic [CP_W-1:0]         main_cp, fa_cp;
    atn_enc_t                enc;

    always_comb
    begin
        idle_path  = (cnt_reg == 2'd0) || (slen_reg < 3'd2) || (slen_reg > 3'd4);
        complete   = ({1'b0, cnt_reg} + 3'd1) >= slen_reg;
        b_len      = lead_len(in_byte);
        s1         = (cnt_reg == 2'd1) ? in_byte : held1_reg;
        s2         = (cnt_reg == 2'd2) ? in_byte : held2_reg;

        held0_next = held0_reg;
        held1_next = held1_reg;
        held2_next = held2_reg;
        cnt_step   = cnt_reg;
        slen_step  = slen_reg;
        main_emit  = 1'b0;
        main_cp    = '0;

        if (idle_path) begin
            cnt_step  = 2'd0;
            slen_step = 3'd0;
            if (b_len == 3'd1) begin
                main_emit = 1'b1;
                main_cp   = {13'd0, in_byte};
            end else if (b_len >= 3'd2) begin
                held0_next = in_byte;
                cnt_step   = 2'd1;
                slen_step  = b_len;
            end
        end else if (complete) begin
            // the new byte is the last of the sequence
            main_emit = 1'b1;
            main_cp   = decode_seq(held0_reg, s1, s2, in_byte, slen_reg);
            cnt_step  = 2'd0;
            slen_step = 3'd0;
        end else begin
            held1_next = s1;
            held2_next = s2;
            cnt_step   = cnt_reg + 2'd1;
        end

        // end of text inside a sequence: drop lead, re-decode the rest
        l1       = lead_len(held1_next);
        l2       = lead_len(held2_next);
        fa_valid = 1'b0;
        fa_cp    = '0;
        fb_keep  = 1'b0;
        if (final_byte) begin
            if (cnt_step == 2'd2) begin
                fa_valid = (l1 == 3'd1);
                fa_cp    = {13'd0, held1_next};
            end else if (cnt_step == 2'd3) begin
                if (l1 == 3'd1) begin
                    fa_valid = 1'b1;
                    fa_cp    = {13'd0, held1_next};
                    fb_keep  = (l2 == 3'd1) && (held2_next != 8'h00);
                end else if (l1 == 3'd2) begin
                    fa_valid = 1'b1;
                    fa_cp    = decode_seq(held1_next, held2_next, 8'h00, 8'h00, 3'd2);
                end else begin
                    fa_valid = (l2 == 3'd1);
                    fa_cp    = {13'd0, held2_next};
                end
            end
        end

        cnt_next  = final_byte ? 2'd0 : cnt_step;
        slen_next = final_byte ? 3'd0 : slen_step;

        enc = encode_cp(main_emit ? main_cp : fa_cp);
        if (!(main_emit || fa_valid))
            enc = '0;

        q_load    = enc.bytes;
        qcnt_load = enc.nbytes + {2'd0, fb_keep};
        if (fb_keep) begin
            // first flushed byte is ASCII, so at most one byte precedes this one
            if (enc.nbytes == 3'd0)
                q_load[0] = held2_next;
            else
                q_load[1] = held2_next;
        end
    end

    assign status.has_result = (qcnt_load != '0) || final_byte;
    assign status.last       = (qcnt_reg <= 3'd1);

    assign has_byte    = (qcnt_reg != '0);
    assign out_byte    = has_byte ? q_reg[0] : 8'h00;
    assign last_of_run = (qcnt_reg <= 3'd1);
    assign end_of_text = fin_reg && (qcnt_reg <= 3'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg  <= 2'd0;
            slen_reg <= 3'd0;
            qcnt_reg <= '0;
            fin_reg  <= 1'b0;
        end else if (cmd.load) begin
            cnt_reg  <= cnt_next;
            slen_reg <= slen_next;
            qcnt_reg <= qcnt_load;
            fin_reg  <= final_byte;
        end else if (cmd.shift && (qcnt_reg != '0)) begin
            qcnt_reg <= qcnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            held2_reg <= held2_next;
            q_reg     <= q_load;
        end else if (cmd.shift) begin
            q_reg <= {8'h00, q_reg[QDEPTH-1:1]};
        end
    end

endmodule

>>> rtl/arabic_text_normalizer.sv
// Channel | Handshake            | Payload
// input   | in_valid / in_stall   | in_byte, final_byte
// output  | out_valid / out_stall | out_byte, has_byte, last_of_run, end_of_text
//
// A byte is taken and all of its output bytes (0..4) are built in that same cycle
// into a four-entry byte queue, then sent one per cycle while out_stall is low.
// Input is stalled while the queue drains; out_stall holds the head byte in place.
// rst_n (async, active low) clears the partial-sequence count and the queue.
module arabic_text_normalizer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       final_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       last_of_run,
    output logic       end_of_text
);
    import atn_pkg::*;

    atn_cmd_t    cmd;
    atn_status_t status;

    // sequencing: accept, then drain queue
    atn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // decode, filter, fold, re-encode
    atn_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_byte     (in_byte),
        .final_byte  (final_byte),
        .out_byte    (out_byte),
        .has_byte    (has_byte),
        .last_of_run (last_of_run),
        .end_of_text (end_of_text)
    );

endmodule

>>> rtl/atn_checker.sv
module atn_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] in_byte,
    input logic       final_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       has_byte,
    input logic       last_of_run,
    input logic       end_of_text
);

    // held output transfer keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(has_byte)
            && $stable(last_of_run) && $stable(end_of_text))
        else $error("output payload changed under stall");

    // a bare end marker closes both the run and the text, with a zero byte
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte |-> last_of_run && end_of_text && (out_byte == 8'h00))
        else $error("bad end marker");

    a_eot_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_text |-> last_of_run)
        else $error("end_of_text without last_of_run");

    // no new input while a run is still draining
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> in_stall)
        else $error("input taken during output run");

endmodule

bind arabic_text_normalizer atn_checker u_atn_checker (.*);

>>> verif/tb_arabic_text_normalizer.sv
`timescale 1ns / 100ps

module tb_arabic_text_normalizer;

    import atn_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 300000;
    localparam int unsigned HOLD_CYCLES   = 80;    // long receiver hold-off
    localparam int unsigned PHASE_BYTES   = 56;    // minimum random bytes per idling phase
    localparam int unsigned DRAIN_CYCLES  = 20;
    localparam int unsigned NUM_PHASES    = 4;
    localparam int unsigned MAX_RUN_BYTES = 4;     // output bytes one input byte can cause

    // Letters worth hitting often: every folded variant, tatweel, superscript
    // alef and the edges of both mark ranges.
    localparam logic [CP_W-1:0] LETTER_CPS [12] = '{
        CP_ALEF_MADDA, CP_ALEF_HAMZA_A, CP_ALEF_HAMZA_B, CP_ALEF_WASLA,
        CP_ALEF_MAQSURA, CP_TEH_MARBUTA, CP_TATWEEL, CP_SUPER_ALEF,
        CP_MARK_A_LO, CP_MARK_A_HI, CP_MARK_B_LO, CP_MARK_B_HI
    };

    // One byte of input text and one output transfer
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } text_byte_t;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       last_of_run;
        logic       end_of_text;
    } norm_out_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       final_byte = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last_of_run;
    logic       end_of_text;

    arabic_text_normalizer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .final_byte  (final_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .has_byte    (has_byte),
        .last_of_run (last_of_run),
        .end_of_text (end_of_text)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Bytes waiting to be offered, and normalized output still owed by the block
    text_byte_t text_q[$];
    norm_out_t  normalized_q[$];

    // Idling knobs, changed only at the falling edge
    int unsigned sender_idle_pct = 0;
    int unsigned stall_pct       = 0;
    logic        hold_req        = 1'b0;
    int unsigned hold_left;

    int unsigned errors          = 0;
    int unsigned cycle_count     = 0;
    int unsigned bytes_queued    = 0;
    int unsigned bytes_accepted  = 0;
    int unsigned texts_done      = 0;
    int unsigned results_checked = 0;
    int unsigned stalled_offers  = 0;

    text_byte_t next_item;
    norm_out_t  want;

    // ------------------------------------------------------------------
    // Predictor: partial-sequence state plus the bytes the current input
    // byte produces.
    // ------------------------------------------------------------------
    logic [7:0] held [3];
    int         held_n  = 0;
    int         seq_len = 0;
    logic [7:0] run_bytes[$];

    function automatic int lead_bytes(input logic [7:0] b);
        if (b[7] == 1'b0)          return 1;
        if (b[7:5] == 3'b110)      return 2;
        if (b[7:4] == 4'b1110)     return 3;
        if (b[7:3] == 5'b11110)    return 4;
        return 0;
    endfunction

    // Continuation bytes are not checked; only their low six bits count
    function automatic logic [CP_W-1:0] decode_cp(input logic [7:0] s [4], input int n);
        case (n)
            1:       return CP_W'(s[0]);
            2:       return CP_W'({s[0][4:0], s[1][5:0]});
            3:       return CP_W'({s[0][3:0], s[1][5:0], s[2][5:0]});
            4:       return {s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
            default: return '0;
        endcase
    endfunction

    // Shortest UTF-8 form; also used to build stimulus
    function automatic int utf8_encode(input logic [CP_W-1:0] cp, output logic [7:0] enc [4]);
        enc = '{default: 8'h00};
        if (cp < 'h80) begin
            enc[0] = cp[7:0];
            return 1;
        end
        if (cp < 'h800) begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
            return 2;
        end
        if (cp < 'h10000) begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
            return 3;
        end
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
        return 4;
    endfunction

    // Drop, fold, re-encode one decoded codepoint into run_bytes
    task automatic keep_cp(input logic [CP_W-1:0] cp_in);
        logic [CP_W-1:0] cp;
        logic [7:0]      enc [4];
        int              n;
        cp = cp_in;
        if (cp == '0 || cp == CP_TATWEEL || cp == CP_SUPER_ALEF ||
            (cp >= CP_MARK_A_LO && cp <= CP_MARK_A_HI) ||
            (cp >= CP_MARK_B_LO && cp <= CP_MARK_B_HI))
            return;
        case (cp)
            CP_ALEF_MADDA, CP_ALEF_HAMZA_A, CP_ALEF_HAMZA_B, CP_ALEF_WASLA: cp = CP_ALEF;
            CP_ALEF_MAQSURA: cp = CP_YEH;
            CP_TEH_MARBUTA:  cp = CP_HEH;
            default: ;
        endcase
        n = utf8_encode(cp, enc);
        for (int k = 0; k < n; k++)
            if (run_bytes.size() < MAX_RUN_BYTES)
                run_bytes = {run_bytes, enc[k]};
    endtask

    // Advance the predictor by one accepted byte and queue what it causes
    task automatic normalize_byte(input logic [7:0] b, input logic fin);
        logic [7:0] s [4];
        norm_out_t  r;
        int         len;
        int         i;
        s = '{default: 8'h00};
        run_bytes.delete();
        if (held_n == 0) begin
            len     = lead_bytes(b);
            seq_len = 0;
            if (len == 1) begin
                keep_cp(CP_W'(b));
            end else if (len >= 2) begin
                held[0] = b;
                held_n  = 1;
                seq_len = len;
            end
        end else if (held_n + 1 >= seq_len) begin
            for (int j = 0; j < held_n; j++)
                s[j] = held[j];
            s[held_n] = b;
            keep_cp(decode_cp(s, seq_len));
            held_n  = 0;
            seq_len = 0;
        end else begin
            held[held_n] = b;
            held_n++;
        end

        // Text ended mid-sequence: lose the lead, re-scan what is held behind it
        if (fin) begin
            i = 1;
            while (i < held_n) begin
                len = lead_bytes(held[i]);
                if (len != 0 && i + len <= held_n) begin
                    s = '{default: 8'h00};
                    for (int j = 0; j < len; j++)
                        s[j] = held[i + j];
                    keep_cp(decode_cp(s, len));
                    i += len;
                end else begin
                    i++;
                end
            end
            held_n  = 0;
            seq_len = 0;
        end

        if (fin && run_bytes.size() == 0) begin
            r = '{data: 8'h00, has_byte: 1'b0, last_of_run: 1'b1, end_of_text: 1'b1};
            normalized_q = {normalized_q, r};
        end
        for (int k = 0; k < run_bytes.size(); k++) begin
            r.data        = run_bytes[k];
            r.has_byte    = 1'b1;
            r.last_of_run = (k == run_bytes.size() - 1);
            r.end_of_text = r.last_of_run && fin;
            normalized_q = {normalized_q, r};
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] b, input logic fin);
        text_byte_t t;
        t.data = b;
        t.fin  = fin;
        text_q = {text_q, t};
        bytes_queued++;
    endtask

    // Well-formed encoding; fin goes on its last byte
    task automatic add_cp(input logic [CP_W-1:0] cp, input logic fin);
        logic [7:0] enc [4];
        int         n;
        n = utf8_encode(cp, enc);
        for (int k = 0; k < n; k++)
            add_byte(enc[k], fin && (k == n - 1));
    endtask

    function automatic logic [CP_W-1:0] random_cp();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 30) return CP_W'($urandom_range(127));
        if (pick < 62) return CP_W'($urandom_range('h6FF, 'h600));
        if (pick < 76) return LETTER_CPS[$urandom_range(11)];
        if (pick < 85) return CP_W'($urandom_range('h7FF, 'h80));
        if (pick < 93) return CP_W'($urandom_range('hFFFF, 'h800));
        return CP_W'($urandom_range('h1FFFFF, 'h10000));
    endfunction

    // Mostly clean codepoints, some noise bytes and cut-off sequences,
    // then one of several ways to end the text.
    task automatic add_text(input int unsigned n_cp);
        logic [7:0] enc [4];
        int         n;
        int         pick;
        for (int unsigned c = 0; c < n_cp; c++) begin
            pick = $urandom_range(99);
            if (pick < 88) begin
                add_cp(random_cp(), 1'b0);
            end else if (pick < 94) begin
                add_byte(8'($urandom_range(255)), 1'b0);
            end else begin
                n = utf8_encode(CP_W'($urandom_range('h1FFFFF, 'h80)), enc);
                for (int k = 0; k < $urandom_range(n - 1, 1); k++)
                    add_byte(enc[k], 1'b0);
            end
        end
        case ($urandom_range(3))
            0: add_cp(random_cp(), 1'b1);
            1: begin
                // 4-byte lead cut short by a complete 2-byte letter
                add_byte(8'hF0 | 8'($urandom_range(7)), 1'b0);
                add_cp(CP_W'($urandom_range('h6FF, 'h600)), 1'b1);
            end
            2: begin
                // 3- or 4-byte lead, then a lone ASCII byte ends the text
                if ($urandom_range(1))
                    add_byte(8'hE0 | 8'($urandom_range(15)), 1'b0);
                else
                    add_byte(8'hF0 | 8'($urandom_range(7)), 1'b0);
                add_byte(8'($urandom_range(127)), 1'b1);
            end
            default: add_byte(8'($urandom_range(255)), 1'b1);
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driver: a new byte is offered once the previous one transferred or
    // the line was idle. A stalled byte stays put.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid   <= 1'b0;
            in_byte    <= 8'h00;
            final_byte <= 1'b0;
        end else begin
            if (in_valid && in_stall)
                stalled_offers++;
            if (!in_valid || !in_stall) begin
                if (in_valid) begin
                    normalize_byte(in_byte, final_byte);
                    bytes_accepted++;
                    if (final_byte)
                        texts_done++;
                end
                if (text_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    next_item  = text_q.pop_front();
                    in_valid   <= 1'b1;
                    in_byte    <= next_item.data;
                    final_byte <= next_item.fin;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off counter, started by a one-cycle request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_req)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------
    // Monitor: every output transfer is matched against the oldest
    // expected byte, field by field. out_stall is also driven here.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (normalized_q.size() == 0) begin
                    $error("unexpected output transfer: out_byte %h has_byte %b", out_byte,
                           has_byte);
                    errors++;
                end else begin
                    want = normalized_q.pop_front();
                    results_checked++;
                    if (out_byte !== want.data) begin
                        $error("out_byte: expected %h, got %h", want.data, out_byte);
                        errors++;
                    end
                    if (has_byte !== want.has_byte) begin
                        $error("has_byte: expected %b, got %b", want.has_byte, has_byte);
                        errors++;
                    end
                    if (last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %b, got %b", want.last_of_run,
                               last_of_run);
                        errors++;
                    end
                    if (end_of_text !== want.end_of_text) begin
                        $error("end_of_text: expected %b, got %b", want.end_of_text,
                               end_of_text);
                        errors++;
                    end
                end
            end
            out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: reset, then four idling phases of random texts, the first
    // led by a directed text. Each phase drains fully before the knobs change.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned phase_start;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int unsigned p = 0; p < NUM_PHASES; p++) begin
            @(negedge clk);
            case (p)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 73; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 73; end
                default: begin sender_idle_pct = 28; stall_pct = 28; end
            endcase

            if (p == 0) begin
                // ASCII, zero, byte extremes as stray leads
                add_byte(8'h41, 1'b0);
                add_byte(8'h00, 1'b0);
                add_byte(8'h80, 1'b0);
                add_byte(8'hFF, 1'b0);
                // overlong zero is dropped, overlong 'A' comes out short
                add_byte(8'hC0, 1'b0);
                add_byte(8'h80, 1'b0);
                add_byte(8'hC1, 1'b0);
                add_byte(8'h81, 1'b0);
                // folds and drops
                add_cp(CP_ALEF_MADDA, 1'b0);
                add_cp(CP_TEH_MARBUTA, 1'b0);
                add_cp(CP_ALEF_MAQSURA, 1'b0);
                add_cp(CP_TATWEEL, 1'b0);
                add_cp(CP_MARK_B_LO, 1'b0);
                // largest 4-byte value
                add_cp(21'h1FFFFF, 1'b0);
                // ends mid-sequence, inner lead too short: bare end marker
                add_byte(8'hF0, 1'b0);
                add_byte(8'hD8, 1'b1);
                // ends mid-sequence, inner pair re-decoded to alef
                add_byte(8'hF0, 1'b0);
                add_byte(8'hD8, 1'b0);
                add_byte(8'hA3, 1'b1);
            end

            phase_start = bytes_queued;
            while (bytes_queued - phase_start < PHASE_BYTES)
                add_text($urandom_range(8, 1));

            // Receiver goes quiet while the sender keeps pushing
            if (p == 0) begin
                hold_req = 1'b1;
                @(negedge clk);
                hold_req = 1'b0;
            end

            while (text_q.size() != 0 || in_valid || normalized_q.size() != 0)
                @(negedge clk);
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (normalized_q.size() != 0) begin
            $error("%0d expected output bytes never arrived", normalized_q.size());
            errors++;
        end

        $display("Run covered %0d input bytes in %0d texts, %0d output transfers checked,",
                 bytes_accepted, texts_done, results_checked);
        $display("four idling mixes and a %0d-cycle output hold (%0d stalled offers).",
                 HOLD_CYCLES, stalled_offers);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
